@@ rtl/sha256_pkg.sv @@
// Shared types for the SHA-256 stream hasher.
// Used by sha256_core and sha256_stream_hasher; no dependencies.
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Commands from the byte sequencer to the compression core.
  typedef struct packed {
    logic       push;       // shift one byte into the block window
    logic [7:0] push_byte;
    logic       start;      // begin a 64-round compression
    logic       init;       // reload the initial hash values
  } core_cmd_t;

endpackage

@@ rtl/sha256_core.sv @@
// SHA-256 compression core: byte-fed block window, one round per cycle.
// Depends on sha256_pkg.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::core_cmd_t cmd,
  input  logic [2:0]            word_sel,
  output logic                  done,
  output sha256_pkg::word_t     digest_word
);
  import sha256_pkg::*;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t win(input logic [511:0] blk, input int unsigned j);
    return blk[511 - 32*j -: 32];
  endfunction

  logic [511:0] blk_r;       // 16-word window, word 0 at the top
  word_t        v_r [8];     // working variables a..h
  word_t        h_r [8];
  logic [5:0]   rnd_r;
  logic         busy_r;
  logic         fin_r;

  word_t w_t, w_new, s0, s1, big0, big1, ch, maj, t1, t2;

  always_comb begin
    w_t   = win(blk_r, 0);
    s0    = ror(win(blk_r, 1), 7) ^ ror(win(blk_r, 1), 18) ^ (win(blk_r, 1) >> 3);
    s1    = ror(win(blk_r, 14), 17) ^ ror(win(blk_r, 14), 19) ^ (win(blk_r, 14) >> 10);
    w_new = s1 + win(blk_r, 9) + s0 + w_t;
    big1  = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + ch + round_k(rnd_r) + w_t;
    big0  = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = big0 + maj;
  end

  assign done        = fin_r;
  assign digest_word = h_r[word_sel];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], cmd.push_byte};
    end else if (busy_r) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (cmd.start) begin
      v_r <= h_r;
    end else if (busy_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= IV;
      rnd_r  <= '0;
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (cmd.init) begin
        h_r <= IV;
      end else if (fin_r) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
    end
  end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: byte intake, padding sequencer, digest beats.
// Depends on sha256_pkg and sha256_core.
//
//   channel | direction | fields                                      | handshake
//   in_     | in        | data_byte[7:0], byte_present, message_end   | in_valid/in_ready
//   out_    | out       | digest_word[31:0], word_index[2:0], last_word | out_valid/out_ready
//
// Message bytes are taken one per cycle while in_ready is high; every 64th byte adds a compression
// (start, 64 rounds on the shared round unit, feed-forward add).
// Finishing pushes pad, zero and length bytes one per cycle outside compressions (up to 64, or up to
// 72 when the pad lands at byte 56 or later), makes a step without a push at the length position
// and runs one or two compressions, then offers eight digest beats. in_ready is low throughout.
// rst_n (synchronous) reloads the initial hash values and clears the counters.
// A stalled out_ready holds the current digest beat; nothing else moves.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  typedef enum logic [2:0] {
    ST_IN, ST_PAD, ST_FILL, ST_LEN, ST_GO, ST_BUSY, ST_OUT
  } state_t;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;
  core_cmd_t   cmd;
  logic        core_done;
  word_t       core_word;

  sha256_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .word_sel    (idx_r),
    .done        (core_done),
    .digest_word (core_word)
  );

  assign in_ready        = (state_r == ST_IN);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = core_word;
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      ST_IN: begin
        if (in_valid) begin
          if (in_byte_present) begin
            cmd.push      = 1'b1;
            cmd.push_byte = in_data_byte;
            cnt_nxt       = cnt_r + 6'd1;
            len_nxt       = len_r + 64'd8;
          end
          if (in_byte_present && cnt_r == LAST_BYTE) begin
            ret_nxt   = in_message_end ? ST_PAD : ST_IN;
            state_nxt = ST_GO;
          end else if (in_message_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push      = 1'b1;
        cmd.push_byte = PAD_BYTE;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == LAST_BYTE) begin
          ret_nxt   = ST_FILL;
          state_nxt = ST_GO;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt_r == LEN_POS) begin
          state_nxt = ST_LEN;
        end else begin
          cmd.push = 1'b1;
          cnt_nxt  = cnt_r + 6'd1;
          if (cnt_r == LAST_BYTE) begin
            ret_nxt   = ST_FILL;
            state_nxt = ST_GO;
          end
        end
      end
      ST_LEN: begin
        cmd.push      = 1'b1;
        cmd.push_byte = len_r[63:56];
        len_nxt       = {len_r[55:0], 8'h00};
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == LAST_BYTE) begin
          ret_nxt   = ST_OUT;
          state_nxt = ST_GO;
        end
      end
      ST_GO: begin
        cmd.start = 1'b1;
        state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (core_done) begin
          state_nxt = ret_r;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.init  = 1'b1;
            cnt_nxt   = '0;
            len_nxt   = '0;
            state_nxt = ST_IN;
          end
        end
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
      ret_r   <= ST_IN;
      cnt_r   <= '0;
      len_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

@@ test/tb_sha256_stream_hasher.sv @@
// Testbench for sha256_stream_hasher: byte stream in, eight digest beats out per message.
// Needs sha256_pkg and the RTL of sha256_stream_hasher; digests predicted locally.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
  import sha256_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 300;

  localparam word_t ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // local copy of the hasher state
  word_t        sha_state [0:7];
  logic [7:0]   blk_bytes [0:63];
  int           blk_fill;
  logic [63:0]  bits_done;
  digest_beat_t digest_q [$];

  int mismatches = 0;
  int items_sent = 0;
  int bytes_sent = 0;
  int messages_done = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int gap_odds = 0;
  bit quiet = 1'b0;

  sha256_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_message_end  (in_message_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress();
    word_t w [0:63];
    word_t v [0:7];
    word_t t1, t2, s0, s1;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    v = sha_state;
    for (r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (r = 0; r < 8; r++)
      sha_state[r] = sha_state[r] + v[r];
  endfunction

  function automatic void clear_hash();
    sha_state = SHA_IV;
    blk_fill  = 0;
    bits_done = '0;
  endfunction

  // updates the local state for one accepted beat, queues the digest on message end
  function automatic void predict_digest(logic [7:0] data, logic present, logic last);
    logic [63:0]  total;
    digest_beat_t beat;
    int i;
    if (present) begin
      blk_bytes[blk_fill] = data;
      blk_fill++;
      if (blk_fill == 64) begin
        sha_compress();
        bits_done = bits_done + 64'd512;
        blk_fill = 0;
      end
    end
    if (!last)
      return;
    total = bits_done + 64'(blk_fill * 8);
    i = blk_fill;
    blk_bytes[i] = 8'h80;
    i++;
    if (i > 56) begin
      while (i < 64) begin
        blk_bytes[i] = 8'h00;
        i++;
      end
      sha_compress();
      i = 0;
    end
    while (i < 56) begin
      blk_bytes[i] = 8'h00;
      i++;
    end
    for (i = 0; i < 8; i++)
      blk_bytes[56+i] = total[63-8*i -: 8];
    sha_compress();
    for (i = 0; i < 8; i++) begin
      beat.word = sha_state[i];
      beat.idx  = 3'(i);
      beat.last = (i == 7);
      digest_q.push_back(beat);
    end
    messages_done++;
    clear_hash();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  // one input beat; called at a rising edge, returns at the edge it is accepted
  task automatic send_beat(logic [7:0] data, logic present, logic last);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_byte_present <= present;
    in_message_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (present || last)
      items_sent++;
    if (present)
      bytes_sent++;
    predict_digest(data, present, last);
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  task automatic send_message(int len, bit drain_after);
    bit end_on_byte;
    int k;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == len - 1));
    end
    if (!end_on_byte)
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    if (drain_after)
      wait_for_digests();
  endtask

  task automatic test_empty_message();
    gap_odds = 0;
    send_beat(8'h00, 1'b0, 1'b1);
    wait_for_digests();
    send_beat(8'h7e, 1'b0, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    wait_for_digests();
  endtask

  task automatic test_byte_with_end();
    gap_odds = 3;
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b1, 1'b1);
  endtask

  task automatic test_ignored_byte();
    gap_odds = 2;
    send_beat(8'h3c, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hc3, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    wait_for_digests();
  endtask

  // lengths lean on the pad boundary and on whole-block multiples
  task automatic test_random_messages(int target);
    int pick, len;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        len = $urandom_range(0, 12);
      else if (pick == 5)
        len = $urandom_range(13, 54);
      else if (pick == 6)
        len = $urandom_range(55, 57);
      else if (pick == 7)
        len = $urandom_range(63, 65);
      else if (pick == 8)
        len = $urandom_range(119, 121);
      else
        len = $urandom_range(126, 128);
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 2;
        2: gap_odds = 4;
        default: gap_odds = 8;
      endcase
      send_message(len, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    send_message($urandom_range(0, 20), 1'b0);
    send_message(56, 1'b0);
    send_message($urandom_range(1, 20), 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1)
        out_ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_beat_t head;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest beat", 32'h0, out_digest_word);
      end else begin
        head = digest_q.pop_front();
        if (out_digest_word !== head.word)
          report_mismatch("digest_word", head.word, out_digest_word);
        if (out_word_index !== head.idx)
          report_mismatch("word_index", 32'(head.idx), 32'(out_word_index));
        if (out_last_word !== head.last)
          report_mismatch("last_word", 32'(head.last), 32'(out_last_word));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_hash();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_byte_with_end();
    test_ignored_byte();
    test_random_messages(RANDOM_ITEMS);
    test_quiet_tail();

    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d messages (%0d bytes, %0d items), %0d digest words compared",
             messages_done, bytes_sent, items_sent, words_checked);
    $display("lengths around the pad boundary and whole blocks, bare finishes, idle steps");
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sha256_pkg.sv
rtl/sha256_core.sv
rtl/sha256_stream_hasher.sv
test/tb_sha256_stream_hasher.sv
